// ===== src/round_robin_task_table_unit_assert.svh =====
// Assertion macros for the task table.
// Each macro takes a label, the clock and the active-low reset, then the property terms.
`ifndef ROUND_ROBIN_TASK_TABLE_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every edge outside reset
`define RRTT_ASSERT_HOLDS(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
    else $error("rrtt: invariant broken");

// Same-cycle implication
`define RRTT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rrtt: implication failed");

// Next-cycle implication
`define RRTT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("rrtt: next-cycle check failed");

`else

`define RRTT_ASSERT_HOLDS(lbl, clk_s, rstn_s, cond)
`define RRTT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define RRTT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== src/rrtt_pkg.sv =====
package rrtt_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int PID_W    = 16;
  localparam int CTX_W    = 32;
  localparam int CODE_W   = 32;

  typedef logic [OP_W-1:0]            op_code_t;
  typedef logic [STATUS_W-1:0]        status_code_t;
  typedef logic [PID_W-1:0]           pid_t;
  typedef logic [CTX_W-1:0]           ctx_t;
  typedef logic signed [CODE_W-1:0]   code_t;

  // Operation codes
  localparam op_code_t OP_SPAWN  = 3'd0;
  localparam op_code_t OP_TICK   = 3'd1;
  localparam op_code_t OP_EXIT   = 3'd2;
  localparam op_code_t OP_KILL   = 3'd3;
  localparam op_code_t OP_ALIVE  = 3'd4;
  localparam op_code_t OP_STATUS = 3'd5;

  // Result status codes
  localparam status_code_t ST_OK        = 2'd0;
  localparam status_code_t ST_NOT_FOUND = 2'd1;
  localparam status_code_t ST_FULL      = 2'd2;
  localparam status_code_t ST_LAST      = 2'd3;

  // Exit status recorded for a killed task
  localparam code_t KILL_CODE = -32'sd9;

endpackage

// ===== src/rrtt_in_if.sv =====
interface rrtt_in_if;
  logic                valid;
  logic                ready;
  rrtt_pkg::op_code_t  op;
  rrtt_pkg::ctx_t      context_in;
  rrtt_pkg::pid_t      pid_in;
  rrtt_pkg::code_t     code_in;

  modport source (output valid, op, context_in, pid_in, code_in, input ready);
  modport sink   (input valid, op, context_in, pid_in, code_in, output ready);
endinterface

// ===== src/rrtt_out_if.sv =====
interface rrtt_out_if;
  logic                   valid;
  logic                   ready;
  rrtt_pkg::status_code_t status;
  rrtt_pkg::pid_t         pid_out;
  rrtt_pkg::ctx_t         context_out;
  logic                   alive;
  rrtt_pkg::code_t        code_out;

  modport source (output valid, status, pid_out, context_out, alive, code_out, input ready);
  modport sink   (input valid, status, pid_out, context_out, alive, code_out, output ready);
endinterface

// ===== src/round_robin_task_table_unit.sv =====
// Task table with a linked round-robin ready list and a ring of exit statuses.
// Items enter on in_chan (valid/ready) carrying op, context_in, pid_in and code_in;
// one result per item leaves on out_chan (status, pid_out, context_out, alive,
// code_out). A small sequencer walks the slot memories one step at a time and
// shares a single pid comparator across all searches, so one item is in work
// at a time and in_chan.ready is high only while the sequencer is idle.
// Per item: tick saves the context and moves to the running task's successor;
// exit and kill of the running task walk to its predecessor unless it is the
// head; alive and kill of another task search the list by pid (kill checks the
// running pid first), and a kill that removes its target then walks to the
// predecessor; a status query scans the exit ring up to a match or its end;
// spawn scans for the lowest free slot, then walks to the tail; an unknown op
// goes straight to the result. The longest item is a kill near the tail.
// Each step of a list walk waits on the registered read of the link memory.
// Reset brings up the kernel task (pid 0) in slot 0 as head and running task,
// clears the exit ring by valid bits and takes items once reset is released.
// The result sits in an output register; the next item is accepted while it
// waits, and the sequencer holds in its final state if the receiver stalls
// with a result still pending.
`include "round_robin_task_table_unit_assert.svh"

module round_robin_task_table_unit #(
  parameter int MAX_TASKS  = 16,
  parameter int RING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  rrtt_in_if.sink     in_chan,
  rrtt_out_if.source  out_chan
);

  localparam int SW     = $clog2(MAX_TASKS);
  localparam int LW     = $clog2(MAX_TASKS + 1);
  localparam int RAW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RIW    = $clog2(RING_DEPTH + 1);
  localparam int RING_W = rrtt_pkg::PID_W + rrtt_pkg::CODE_W;

  localparam logic [LW-1:0]  LINK_NULL = LW'(MAX_TASKS);
  localparam logic [SW-1:0]  SLOT_LAST = SW'(MAX_TASKS - 1);
  localparam logic [RAW-1:0] RING_LAST = RAW'(RING_DEPTH - 1);
  localparam logic [RIW-1:0] RING_END  = RIW'(RING_DEPTH);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_SP_FREE = 20'h00002,
    S_SP_WR   = 20'h00004,
    S_WALK_RD = 20'h00008,
    S_WALK    = 20'h00010,
    S_TK      = 20'h00020,
    S_TK_NXT  = 20'h00040,
    S_RM_RD   = 20'h00080,
    S_RM_CHK  = 20'h00100,
    S_FP_RD   = 20'h00200,
    S_FP      = 20'h00400,
    S_K_RD    = 20'h00800,
    S_K_CHK   = 20'h01000,
    S_SRCH_RD = 20'h02000,
    S_SRCH    = 20'h04000,
    S_RS0     = 20'h08000,
    S_RS      = 20'h10000,
    S_FIN_RD  = 20'h20000,
    S_FIN     = 20'h40000,
    S_SPARE   = 20'h80000
  } state_t;

  // control state
  state_t                  state_r, state_nxt;
  logic [SW-1:0]           head_r, head_nxt;
  logic [SW-1:0]           run_r, run_nxt;
  rrtt_pkg::pid_t          pid_cnt_r, pid_cnt_nxt;
  logic [RAW-1:0]          ring_wr_r, ring_wr_nxt;
  logic [MAX_TASKS-1:0]    slot_used_r;
  logic [MAX_TASKS-1:0]    pid_vld_r, link_vld_r, ctx_vld_r;
  logic [RING_DEPTH-1:0]   ring_vld_r;
  logic                    out_valid_r, out_valid_nxt;

  // sequencer working registers
  logic [SW-1:0]           walk_r, walk_nxt;
  logic [SW-1:0]           tgt_r, tgt_nxt;
  logic [LW-1:0]           succ_r, succ_nxt;
  logic                    exiting_r, exiting_nxt;
  logic                    spawned_r, spawned_nxt;
  rrtt_pkg::pid_t          new_pid_r, new_pid_nxt;
  rrtt_pkg::status_code_t  status_r, status_nxt;
  logic                    alive_r, alive_nxt;
  rrtt_pkg::code_t         code_out_r, code_out_nxt;
  logic [RIW-1:0]          ring_idx_r, ring_idx_nxt;

  // latched item
  rrtt_pkg::op_code_t      op_r;
  rrtt_pkg::ctx_t          ctx_in_r;
  rrtt_pkg::pid_t          pid_in_r;
  rrtt_pkg::code_t         rm_code_r;

  // output register
  rrtt_pkg::status_code_t  out_status_r;
  rrtt_pkg::pid_t          out_pid_r;
  rrtt_pkg::ctx_t          out_ctx_r;
  logic                    out_alive_r;
  rrtt_pkg::code_t         out_code_r;

  // memory ports
  logic                    pid_we, pid_re;
  logic [SW-1:0]           pid_waddr, pid_raddr;
  rrtt_pkg::pid_t          pid_wdata, pid_rdata;
  logic                    link_we, link_re;
  logic [SW-1:0]           link_waddr, link_raddr;
  logic [LW-1:0]           link_wdata, link_rdata;
  logic                    ctx_we, ctx_re;
  logic [SW-1:0]           ctx_waddr, ctx_raddr;
  rrtt_pkg::ctx_t          ctx_wdata, ctx_rdata;
  logic                    ring_we, ring_re;
  logic [RAW-1:0]          ring_raddr;
  logic [RING_W-1:0]       ring_wdata, ring_rdata;

  // read-time valid bits, taken with each read
  logic                    pid_vq_r, link_vq_r, ctx_vq_r, ring_vq_r;

  logic                    used_set, used_clr;
  logic                    out_load;
  logic                    in_acc;

  rrtt_pkg::pid_t          pid_eff, ring_pid_eff, cmp_a;
  logic [LW-1:0]           link_eff;
  rrtt_pkg::ctx_t          ctx_eff;
  rrtt_pkg::code_t         ring_code_eff;
  logic                    link_ok, pid_hit;
  logic [SW-1:0]           link_slot;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  // memory data, with never-written entries reading as their reset value
  assign pid_eff       = pid_vq_r  ? pid_rdata  : '0;
  assign link_eff      = link_vq_r ? link_rdata : LINK_NULL;
  assign ctx_eff       = ctx_vq_r  ? ctx_rdata  : '0;
  assign ring_pid_eff  = ring_vq_r ? ring_rdata[RING_W-1 -: rrtt_pkg::PID_W] : '0;
  assign ring_code_eff = ring_vq_r ? ring_rdata[rrtt_pkg::CODE_W-1:0] : '0;
  assign link_ok       = (link_eff < LINK_NULL);
  assign link_slot     = link_eff[SW-1:0];

  // shared pid comparator
  assign cmp_a   = (state_r == S_RS) ? ring_pid_eff : pid_eff;
  assign pid_hit = (cmp_a == pid_in_r);

  assign ring_wdata = {pid_eff, rm_code_r};

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    run_nxt      = run_r;
    pid_cnt_nxt  = pid_cnt_r;
    ring_wr_nxt  = ring_wr_r;
    walk_nxt     = walk_r;
    tgt_nxt      = tgt_r;
    succ_nxt     = succ_r;
    exiting_nxt  = exiting_r;
    spawned_nxt  = spawned_r;
    new_pid_nxt  = new_pid_r;
    status_nxt   = status_r;
    alive_nxt    = alive_r;
    code_out_nxt = code_out_r;
    ring_idx_nxt = ring_idx_r;

    pid_we     = 1'b0;
    pid_waddr  = tgt_r;
    pid_wdata  = pid_cnt_r;
    pid_re     = 1'b0;
    pid_raddr  = walk_r;
    link_we    = 1'b0;
    link_waddr = walk_r;
    link_wdata = LINK_NULL;
    link_re    = 1'b0;
    link_raddr = walk_r;
    ctx_we     = 1'b0;
    ctx_waddr  = tgt_r;
    ctx_wdata  = ctx_in_r;
    ctx_re     = 1'b0;
    ctx_raddr  = run_r;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    ring_raddr = ring_idx_r[RAW-1:0];
    used_set   = 1'b0;
    used_clr   = 1'b0;
    out_load   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt   = rrtt_pkg::ST_OK;
          alive_nxt    = 1'b0;
          code_out_nxt = '0;
          spawned_nxt  = 1'b0;
          unique case (in_chan.op)
            rrtt_pkg::OP_SPAWN: begin
              walk_nxt  = '0;
              state_nxt = S_SP_FREE;
            end
            rrtt_pkg::OP_TICK: begin
              state_nxt = S_TK;
            end
            rrtt_pkg::OP_EXIT: begin
              tgt_nxt     = run_r;
              exiting_nxt = 1'b1;
              state_nxt   = S_RM_RD;
            end
            rrtt_pkg::OP_KILL: begin
              state_nxt = S_K_RD;
            end
            rrtt_pkg::OP_ALIVE: begin
              walk_nxt  = head_r;
              state_nxt = S_SRCH_RD;
            end
            rrtt_pkg::OP_STATUS: begin
              state_nxt = S_RS0;
            end
            default: begin
              status_nxt = rrtt_pkg::ST_NOT_FOUND;
              state_nxt  = S_FIN_RD;
            end
          endcase
        end
      end

      // lowest free slot, one slot a cycle
      S_SP_FREE: begin
        if (!slot_used_r[walk_r]) begin
          tgt_nxt   = walk_r;
          state_nxt = S_SP_WR;
        end else if (walk_r == SLOT_LAST) begin
          status_nxt = rrtt_pkg::ST_FULL;
          state_nxt  = S_FIN_RD;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end

      // fill the new slot, then walk to the tail
      S_SP_WR: begin
        pid_we      = 1'b1;
        ctx_we      = 1'b1;
        link_we     = 1'b1;
        link_waddr  = tgt_r;
        link_wdata  = LINK_NULL;
        used_set    = 1'b1;
        new_pid_nxt = pid_cnt_r;
        spawned_nxt = 1'b1;
        pid_cnt_nxt = pid_cnt_r + 1'b1;
        walk_nxt    = head_r;
        state_nxt   = S_WALK_RD;
      end

      S_WALK_RD: begin
        link_re   = 1'b1;
        state_nxt = S_WALK;
      end

      S_WALK: begin
        if (link_ok) begin
          walk_nxt  = link_slot;
          state_nxt = S_WALK_RD;
        end else begin
          link_we    = 1'b1;
          link_wdata = LW'(tgt_r);
          state_nxt  = S_FIN_RD;
        end
      end

      // save context and fetch successor of the running task
      S_TK: begin
        ctx_we     = 1'b1;
        ctx_waddr  = run_r;
        link_re    = 1'b1;
        link_raddr = run_r;
        state_nxt  = S_TK_NXT;
      end

      S_TK_NXT: begin
        run_nxt   = link_ok ? link_slot : head_r;
        state_nxt = S_FIN_RD;
      end

      // removal of slot tgt_r
      S_RM_RD: begin
        pid_re     = 1'b1;
        pid_raddr  = tgt_r;
        link_re    = 1'b1;
        link_raddr = tgt_r;
        state_nxt  = S_RM_CHK;
      end

      S_RM_CHK: begin
        succ_nxt = link_eff;
        if (exiting_r && (tgt_r == head_r) && !link_ok) begin
          status_nxt = rrtt_pkg::ST_LAST;
          state_nxt  = S_FIN_RD;
        end else begin
          ring_we     = 1'b1;
          ring_wr_nxt = (ring_wr_r == RING_LAST) ? '0 : ring_wr_r + 1'b1;
          used_clr    = 1'b1;
          if (tgt_r == head_r) begin
            head_nxt = link_slot;
            if (exiting_r) begin
              run_nxt = link_slot;
            end
            state_nxt = S_FIN_RD;
          end else begin
            walk_nxt  = head_r;
            state_nxt = S_FP_RD;
          end
        end
      end

      // find the predecessor and splice it past the removed slot
      S_FP_RD: begin
        link_re   = 1'b1;
        state_nxt = S_FP;
      end

      S_FP: begin
        if ((link_eff == LW'(tgt_r)) || !link_ok) begin
          if (link_ok) begin
            link_we    = 1'b1;
            link_wdata = succ_r;
          end
          if (exiting_r) begin
            run_nxt = (succ_r < LINK_NULL) ? succ_r[SW-1:0] : head_r;
          end
          state_nxt = S_FIN_RD;
        end else begin
          walk_nxt  = link_slot;
          state_nxt = S_FP_RD;
        end
      end

      // kill: the running pid is checked first
      S_K_RD: begin
        pid_re    = 1'b1;
        pid_raddr = run_r;
        state_nxt = S_K_CHK;
      end

      S_K_CHK: begin
        if (pid_hit) begin
          tgt_nxt     = run_r;
          exiting_nxt = 1'b1;
          state_nxt   = S_RM_RD;
        end else begin
          walk_nxt  = head_r;
          state_nxt = S_SRCH_RD;
        end
      end

      // list search by pid, for kill and alive
      S_SRCH_RD: begin
        pid_re    = 1'b1;
        link_re   = 1'b1;
        state_nxt = S_SRCH;
      end

      S_SRCH: begin
        if (pid_hit) begin
          if (op_r == rrtt_pkg::OP_ALIVE) begin
            alive_nxt = 1'b1;
            state_nxt = S_FIN_RD;
          end else if (walk_r == head_r) begin
            status_nxt = rrtt_pkg::ST_NOT_FOUND;
            state_nxt  = S_FIN_RD;
          end else begin
            tgt_nxt     = walk_r;
            exiting_nxt = 1'b0;
            state_nxt   = S_RM_RD;
          end
        end else if (link_ok) begin
          walk_nxt  = link_slot;
          state_nxt = S_SRCH_RD;
        end else begin
          if (op_r != rrtt_pkg::OP_ALIVE) begin
            status_nxt = rrtt_pkg::ST_NOT_FOUND;
          end
          state_nxt = S_FIN_RD;
        end
      end

      // exit ring scan, one entry a cycle with the read one ahead
      S_RS0: begin
        ring_re      = 1'b1;
        ring_raddr   = '0;
        ring_idx_nxt = RIW'(1);
        state_nxt    = S_RS;
      end

      S_RS: begin
        if (pid_hit) begin
          code_out_nxt = ring_code_eff;
          state_nxt    = S_FIN_RD;
        end else if (ring_idx_r == RING_END) begin
          state_nxt = S_FIN_RD;
        end else begin
          ring_re      = 1'b1;
          ring_idx_nxt = ring_idx_r + 1'b1;
        end
      end

      // running task's pid and context for the result
      S_FIN_RD: begin
        pid_re    = 1'b1;
        pid_raddr = run_r;
        ctx_re    = 1'b1;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      run_r        <= '0;
      pid_cnt_r    <= rrtt_pkg::PID_W'(1);
      ring_wr_r    <= '0;
      slot_used_r  <= MAX_TASKS'(1);
      pid_vld_r    <= '0;
      link_vld_r   <= '0;
      ctx_vld_r    <= '0;
      ring_vld_r   <= '0;
      out_valid_r  <= 1'b0;
      walk_r       <= '0;
      tgt_r        <= '0;
      succ_r       <= LINK_NULL;
      exiting_r    <= 1'b0;
      spawned_r    <= 1'b0;
      new_pid_r    <= '0;
      status_r     <= rrtt_pkg::ST_OK;
      alive_r      <= 1'b0;
      code_out_r   <= '0;
      ring_idx_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      run_r        <= run_nxt;
      pid_cnt_r    <= pid_cnt_nxt;
      ring_wr_r    <= ring_wr_nxt;
      out_valid_r  <= out_valid_nxt;
      walk_r       <= walk_nxt;
      tgt_r        <= tgt_nxt;
      succ_r       <= succ_nxt;
      exiting_r    <= exiting_nxt;
      spawned_r    <= spawned_nxt;
      new_pid_r    <= new_pid_nxt;
      status_r     <= status_nxt;
      alive_r      <= alive_nxt;
      code_out_r   <= code_out_nxt;
      ring_idx_r   <= ring_idx_nxt;
      if (used_set) begin
        slot_used_r[tgt_r] <= 1'b1;
      end
      if (used_clr) begin
        slot_used_r[tgt_r] <= 1'b0;
      end
      if (pid_we) begin
        pid_vld_r[pid_waddr] <= 1'b1;
      end
      if (link_we) begin
        link_vld_r[link_waddr] <= 1'b1;
      end
      if (ctx_we) begin
        ctx_vld_r[ctx_waddr] <= 1'b1;
      end
      if (ring_we) begin
        ring_vld_r[ring_wr_r] <= 1'b1;
      end
    end
  end

  // item latch, read-time valid bits and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_chan.op;
      ctx_in_r  <= in_chan.context_in;
      pid_in_r  <= in_chan.pid_in;
      rm_code_r <= (in_chan.op == rrtt_pkg::OP_KILL) ? rrtt_pkg::KILL_CODE : in_chan.code_in;
    end
    if (pid_re) begin
      pid_vq_r <= pid_vld_r[pid_raddr];
    end
    if (link_re) begin
      link_vq_r <= link_vld_r[link_raddr];
    end
    if (ctx_re) begin
      ctx_vq_r <= ctx_vld_r[ctx_raddr];
    end
    if (ring_re) begin
      ring_vq_r <= ring_vld_r[ring_raddr];
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_pid_r    <= spawned_r ? new_pid_r : pid_eff;
      out_ctx_r    <= ctx_eff;
      out_alive_r  <= alive_r;
      out_code_r   <= code_out_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.pid_out     = out_pid_r;
  assign out_chan.context_out = out_ctx_r;
  assign out_chan.alive       = out_alive_r;
  assign out_chan.code_out    = out_code_r;

  // slot memories
  rrtt_ram #(.WIDTH(rrtt_pkg::PID_W), .DEPTH(MAX_TASKS)) u_pid_ram (
    .clk   (clk),
    .we    (pid_we),
    .waddr (pid_waddr),
    .wdata (pid_wdata),
    .re    (pid_re),
    .raddr (pid_raddr),
    .rdata (pid_rdata)
  );

  rrtt_ram #(.WIDTH(LW), .DEPTH(MAX_TASKS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  rrtt_ram #(.WIDTH(rrtt_pkg::CTX_W), .DEPTH(MAX_TASKS)) u_ctx_ram (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (ctx_waddr),
    .wdata (ctx_wdata),
    .re    (ctx_re),
    .raddr (ctx_raddr),
    .rdata (ctx_rdata)
  );

  // exit ring: pid in the upper bits, code below
  rrtt_ram #(.WIDTH(RING_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_wr_r),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // checks
  `RRTT_ASSERT_HOLDS(a_head_used, clk, rst_n, slot_used_r[head_r])
  `RRTT_ASSERT_IMPL(a_run_used_idle, clk, rst_n, state_r == S_IDLE, slot_used_r[run_r])
  `RRTT_ASSERT_IMPL(a_out_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_FIN)
  `RRTT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_chan.ready)

endmodule

// ===== src/rrtt_ram.sv =====
module rrtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/sv/tb_round_robin_task_table_unit.sv =====
`timescale 1ns / 1ps

module tb_round_robin_task_table_unit;

  localparam int NUM_SLOTS    = 16;
  localparam int EXIT_DEPTH   = 32;
  localparam int NO_LINK      = NUM_SLOTS;
  localparam int RANDOM_ITEMS = 1250;
  localparam int MAX_REPORTS  = 10;
  // covers the slowest item, a kill near the tail, plus a full sender
  // gap and receiver stall
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 64;
  localparam int SENDER       = 0;
  localparam int RECEIVER     = 1;

  // op values the block does not implement
  localparam rrtt_pkg::op_code_t OP_BAD_LO = 3'd6;
  localparam rrtt_pkg::op_code_t OP_BAD_HI = 3'd7;

  typedef struct {
    rrtt_pkg::status_code_t status;
    rrtt_pkg::pid_t         pid;
    rrtt_pkg::ctx_t         ctx;
    logic                   alive;
    rrtt_pkg::code_t        code;
  } sched_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  rrtt_in_if  in_chan ();
  rrtt_out_if out_chan ();

  round_robin_task_table_unit #(
    .MAX_TASKS  (NUM_SLOTS),
    .RING_DEPTH (EXIT_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler image kept by the testbench
  logic            slot_busy  [NUM_SLOTS];
  rrtt_pkg::pid_t  slot_owner [NUM_SLOTS];
  int              slot_next  [NUM_SLOTS];
  rrtt_pkg::ctx_t  slot_ctx   [NUM_SLOTS];
  int              list_head;
  int              on_cpu;
  rrtt_pkg::pid_t  pid_seq;
  rrtt_pkg::pid_t  exit_log_pid  [EXIT_DEPTH];
  rrtt_pkg::code_t exit_log_code [EXIT_DEPTH];
  int              exit_log_wr;

  sched_reply_t pending_replies[$];
  int           fail_count = 0;
  int           calm_left [2];
  logic         result_taken = 1'b0;
  int           out_stall = 0;
  int           quiet_cycles = 0;

  // Record the exit, unlink slot s from the ready list and free it
  function automatic void unlink_slot(int s, rrtt_pkg::code_t code);
    int succ, t, k;
    logic done;
    succ = slot_next[s];
    exit_log_pid[exit_log_wr]  = slot_owner[s];
    exit_log_code[exit_log_wr] = code;
    exit_log_wr = (exit_log_wr + 1) % EXIT_DEPTH;
    if (s == list_head) begin
      list_head = succ;
    end else begin
      t = list_head;
      k = 0;
      done = 1'b0;
      while (!done && k < NUM_SLOTS && t < NUM_SLOTS) begin
        if (slot_next[t] == s) begin
          slot_next[t] = succ;
          done = 1'b1;
        end else begin
          t = slot_next[t];
          k++;
        end
      end
    end
    slot_busy[s] = 1'b0;
    slot_next[s] = NO_LINK;
    slot_ctx[s]  = '0;
  endfunction

  // Running task leaves; refused when it is the only task
  function automatic rrtt_pkg::status_code_t retire_running(rrtt_pkg::code_t code);
    int succ;
    if (on_cpu == list_head && slot_next[on_cpu] >= NUM_SLOTS) return rrtt_pkg::ST_LAST;
    succ = slot_next[on_cpu];
    unlink_slot(on_cpu, code);
    on_cpu = (succ < NUM_SLOTS) ? succ : list_head;
    return rrtt_pkg::ST_OK;
  endfunction

  // Apply one item to the scheduler image and return the reply it should give
  function automatic sched_reply_t predict_reply(rrtt_pkg::op_code_t op,
                                                 rrtt_pkg::ctx_t ctx,
                                                 rrtt_pkg::pid_t pid,
                                                 rrtt_pkg::code_t code);
    sched_reply_t r;
    int s, t, k;
    logic spawned;
    rrtt_pkg::pid_t fresh;
    r.status = rrtt_pkg::ST_OK;
    r.alive  = 1'b0;
    r.code   = '0;
    spawned  = 1'b0;
    fresh    = '0;
    case (op)
      rrtt_pkg::OP_SPAWN: begin
        s = 0;
        while (s < NUM_SLOTS && slot_busy[s]) s++;
        if (s >= NUM_SLOTS) begin
          r.status = rrtt_pkg::ST_FULL;
        end else begin
          slot_busy[s]  = 1'b1;
          slot_owner[s] = pid_seq;
          fresh         = pid_seq;
          pid_seq       = pid_seq + 16'd1;
          slot_ctx[s]   = ctx;
          slot_next[s]  = NO_LINK;
          t = list_head;
          k = 0;
          while (k < NUM_SLOTS && slot_next[t] < NUM_SLOTS) begin
            t = slot_next[t];
            k++;
          end
          slot_next[t] = s;
          spawned = 1'b1;
        end
      end
      rrtt_pkg::OP_TICK: begin
        slot_ctx[on_cpu] = ctx;
        on_cpu = (slot_next[on_cpu] < NUM_SLOTS) ? slot_next[on_cpu] : list_head;
      end
      rrtt_pkg::OP_EXIT: r.status = retire_running(code);
      rrtt_pkg::OP_KILL: begin
        if (slot_owner[on_cpu] == pid) begin
          r.status = retire_running(rrtt_pkg::KILL_CODE);
        end else begin
          t = list_head;
          k = 0;
          while (k < NUM_SLOTS && t < NUM_SLOTS && slot_owner[t] != pid) begin
            t = slot_next[t];
            k++;
          end
          if (t >= NUM_SLOTS || slot_owner[t] != pid || t == list_head)
            r.status = rrtt_pkg::ST_NOT_FOUND;
          else
            unlink_slot(t, rrtt_pkg::KILL_CODE);
        end
      end
      rrtt_pkg::OP_ALIVE: begin
        t = list_head;
        k = 0;
        while (k < NUM_SLOTS && t < NUM_SLOTS && !r.alive) begin
          if (slot_owner[t] == pid) r.alive = 1'b1;
          t = slot_next[t];
          k++;
        end
      end
      rrtt_pkg::OP_STATUS: begin
        k = 0;
        while (k < EXIT_DEPTH && exit_log_pid[k] != pid) k++;
        if (k < EXIT_DEPTH) r.code = exit_log_code[k];
      end
      default: r.status = rrtt_pkg::ST_NOT_FOUND;
    endcase
    r.pid = spawned ? fresh : slot_owner[on_cpu];
    r.ctx = slot_ctx[on_cpu];
    return r;
  endfunction

  // Wait before the next item: mostly a random draw, with calm runs of no wait
  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic rrtt_pkg::pid_t pick_live_pid();
    int s;
    s = $urandom_range(0, NUM_SLOTS - 1);
    while (!slot_busy[s]) s = $urandom_range(0, NUM_SLOTS - 1);
    return slot_owner[s];
  endfunction

  function automatic rrtt_pkg::pid_t pick_gone_pid();
    return exit_log_pid[$urandom_range(0, EXIT_DEPTH - 1)];
  endfunction

  function automatic rrtt_pkg::code_t random_code();
    case ($urandom_range(0, 7))
      0:       return {1'b1, 31'd0};
      1:       return {1'b0, {31{1'b1}}};
      2:       return '1;
      default: return rrtt_pkg::code_t'($urandom);
    endcase
  endfunction

  // Present one item, hold it until taken, then log the reply it should give
  task automatic send_item(rrtt_pkg::op_code_t op, rrtt_pkg::ctx_t ctx,
                           rrtt_pkg::pid_t pid, rrtt_pkg::code_t code);
    int gap;
    gap = draw_wait(SENDER);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.op         <= op;
    in_chan.context_in <= ctx;
    in_chan.pid_in     <= pid;
    in_chan.code_in    <= code;
    @(posedge clk);
    while (!(in_chan.valid && in_chan.ready)) @(posedge clk);
    pending_replies.push_back(predict_reply(op, ctx, pid, code));
  endtask

  task automatic apply_reset();
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.op         = rrtt_pkg::OP_SPAWN;
    in_chan.context_in = '0;
    in_chan.pid_in     = '0;
    in_chan.code_in    = '0;
    calm_left[SENDER]   = 0;
    calm_left[RECEIVER] = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_busy[i]  = (i == 0);
      slot_owner[i] = '0;
      slot_next[i]  = NO_LINK;
      slot_ctx[i]   = '0;
    end
    for (int i = 0; i < EXIT_DEPTH; i++) begin
      exit_log_pid[i]  = '0;
      exit_log_code[i] = '0;
    end
    list_head   = 0;
    on_cpu      = 0;
    pid_seq     = 16'd1;
    exit_log_wr = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // Kernel alone: a tick, refusals of exit and kill, and the unused op values
  task automatic test_lone_kernel();
    send_item(rrtt_pkg::OP_TICK, 32'hFFFF_FFFF, 16'h0000, '0);
    send_item(rrtt_pkg::OP_EXIT, '0, 16'h0000, {1'b0, {31{1'b1}}});
    send_item(rrtt_pkg::OP_KILL, '0, 16'h0000, '0);
    send_item(OP_BAD_LO, 32'hFFFF_FFFF, 16'hFFFF, '1);
    send_item(OP_BAD_HI, '0, 16'hFFFF, '0);
  endtask

  // Spawn until the table refuses
  task automatic test_fill_table();
    rrtt_pkg::ctx_t ctx;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ctx = (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : rrtt_pkg::ctx_t'($urandom);
      send_item(rrtt_pkg::OP_SPAWN, ctx, rrtt_pkg::pid_t'($urandom), '0);
    end
  endtask

  // A tick, head kill refused, middle kill, exit of the running task and its recorded code
  task automatic test_unlink_paths();
    rrtt_pkg::pid_t leaving;
    send_item(rrtt_pkg::OP_TICK, rrtt_pkg::ctx_t'($urandom), '0, '0);
    send_item(rrtt_pkg::OP_KILL, '0, slot_owner[list_head], '0);
    send_item(rrtt_pkg::OP_KILL, '0, slot_owner[5], '0);
    leaving = slot_owner[on_cpu];
    send_item(rrtt_pkg::OP_EXIT, '0, '0, {1'b1, 31'd0});
    send_item(rrtt_pkg::OP_STATUS, '0, leaving, '0);
  endtask

  // Random traffic in phases that grow, shrink or churn the table
  task automatic test_random_traffic(int n_items);
    int mode, roll, sel;
    int lim_spawn, lim_tick, lim_exit, lim_kill, lim_alive, lim_status;
    rrtt_pkg::op_code_t op;
    rrtt_pkg::pid_t pid;
    rrtt_pkg::code_t code;
    mode = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) mode = $urandom_range(0, 2);
      case (mode)
        1:       begin lim_spawn = 45; lim_tick = 60; lim_exit = 65; lim_kill = 73;
                   lim_alive = 83; lim_status = 95; end
        2:       begin lim_spawn = 8;  lim_tick = 23; lim_exit = 50; lim_kill = 75;
                   lim_alive = 85; lim_status = 97; end
        default: begin lim_spawn = 22; lim_tick = 40; lim_exit = 52; lim_kill = 68;
                   lim_alive = 81; lim_status = 96; end
      endcase
      roll = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      pid  = rrtt_pkg::pid_t'($urandom);
      code = rrtt_pkg::code_t'($urandom);
      if (roll < lim_spawn) begin
        op = rrtt_pkg::OP_SPAWN;
      end else if (roll < lim_tick) begin
        op = rrtt_pkg::OP_TICK;
      end else if (roll < lim_exit) begin
        op = rrtt_pkg::OP_EXIT;
        code = random_code();
      end else if (roll < lim_kill) begin
        op = rrtt_pkg::OP_KILL;
        if (sel < 55)      pid = pick_live_pid();
        else if (sel < 70) pid = slot_owner[on_cpu];
        else if (sel < 85) pid = pick_gone_pid();
      end else if (roll < lim_alive) begin
        op = rrtt_pkg::OP_ALIVE;
        if (sel < 50)      pid = pick_live_pid();
        else if (sel < 80) pid = pick_gone_pid();
      end else if (roll < lim_status) begin
        op = rrtt_pkg::OP_STATUS;
        if (sel < 60)      pid = pick_gone_pid();
        else if (sel < 75) pid = pick_live_pid();
      end else begin
        op = sel[0] ? OP_BAD_HI : OP_BAD_LO;
      end
      send_item(op, rrtt_pkg::ctx_t'($urandom), pid, code);
    end
  endtask

  // Compare each reply with the oldest one still owed
  always @(posedge clk) begin
    sched_reply_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      result_taken = 1'b1;
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] reply with none owed: st=%0d pid=%0d ctx=%h alive=%b code=%0d",
                   $realtime, out_chan.status, out_chan.pid_out, out_chan.context_out,
                   out_chan.alive, out_chan.code_out);
      end else begin
        want = pending_replies.pop_front();
        if (want.status !== out_chan.status || want.pid !== out_chan.pid_out ||
            want.ctx !== out_chan.context_out || want.alive !== out_chan.alive ||
            want.code !== out_chan.code_out) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: want %0d/%0d/%h/%b/%0d got %0d/%0d/%h/%b/%0d",
                     $realtime, want.status, want.pid, want.ctx, want.alive, want.code,
                     out_chan.status, out_chan.pid_out, out_chan.context_out,
                     out_chan.alive, out_chan.code_out);
        end
      end
    end
  end

  // Receiver stalls for a random spell after each item it takes
  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 1'b0;
      out_stall = draw_wait(RECEIVER);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    apply_reset();
    test_lone_kernel();
    test_fill_table();
    test_unlink_paths();
    test_random_traffic(RANDOM_ITEMS);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
